// ===== sv/twc_pkg.sv =====
// Shared types and constants for the token whitelist cache.
`default_nettype none

package twc_pkg;

	localparam int TOKEN_W    = 64;
	localparam int MODE_W     = 3;
	localparam int SLOT_FLD_W = 5;
	// wide enough for the largest supported table (256 slots)
	localparam int SLOT_IDX_W = 8;

	localparam logic [MODE_W-1:0] MODE_SAVE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [SLOT_FLD_W-1:0] slot_index;
		logic [TOKEN_W-1:0]    token_value;
	} req_t;

	typedef struct packed {
		logic                  result_ok;
		logic [SLOT_FLD_W-1:0] result_slot;
		logic [TOKEN_W-1:0]    result_token;
	} rsp_t;

	// search state handed from one cell to the next
	typedef struct packed {
		logic                  vld;
		logic                  hit;
		logic [SLOT_IDX_W-1:0] hit_slot;
		logic                  free;
		logic [SLOT_IDX_W-1:0] free_slot;
	} probe_t;

	// per-cell update strobes
	typedef struct packed {
		logic wr;
		logic inv;
		logic clr;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/twc_cell.sv =====
// One table slot: valid mark, token store and one step of the search chain.
`default_nettype none

module twc_cell import twc_pkg::*; #(
	parameter int TOKEN_BITS = 64,
	parameter int CELL_INDEX = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [TOKEN_BITS-1:0] key,
	input  wire probe_t                probe_in,
	output probe_t                     probe_out,
	output logic                       valid,
	output logic [TOKEN_BITS-1:0]      token
);

	localparam logic [SLOT_IDX_W-1:0] CELL_SLOT = SLOT_IDX_W'(CELL_INDEX);

	logic                  valid_q;
	logic [TOKEN_BITS-1:0] token_q;
	probe_t                probe_nxt;
	probe_t                probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr || ctl.inv) begin
			valid_q <= 1'b0;
		end else if (ctl.wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			token_q <= key;
		end
	end

	// first match and first free slot win: later cells leave them alone
	always_comb begin
		probe_nxt = probe_in;
		if (probe_in.vld) begin
			if (!probe_in.hit && valid_q && (token_q == key)) begin
				probe_nxt.hit      = 1'b1;
				probe_nxt.hit_slot = CELL_SLOT;
			end
			if (!probe_in.free && !valid_q) begin
				probe_nxt.free      = 1'b1;
				probe_nxt.free_slot = CELL_SLOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
		end
	end

	assign probe_out = probe_q;
	assign valid     = valid_q;
	assign token     = token_q;

endmodule

`default_nettype wire

// ===== sv/token_whitelist_cache.sv =====
// Token whitelist cache top level: command sequencing and the row of slot cells.
`default_nettype none

// Save and find send a search down the row of slot cells, one cell per
// cycle, each cell registering the search state in turn, so the length of
// the cell row sets how long they take from the start transfer to the done
// strobe. Remove, get, clear all and unknown modes pass through the response
// state instead. busy stays high from the start transfer until done rises,
// and done marks the result on rsp for exactly one cycle; the receiver cannot
// stall it, so the result must be taken in that cycle. A new start may be
// given in the cycle that done is high.

module token_whitelist_cache import twc_pkg::*; #(
	parameter int SLOT_COUNT  = 32,
	parameter int TOKEN_BYTES = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int TOKEN_BITS = 8 * TOKEN_BYTES;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDXW       = ((SLOT_W > SLOT_FLD_W) ? SLOT_W : SLOT_FLD_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t                  state_q;
	logic                    launch_q;
	logic [MODE_W-1:0]       mode_q;
	logic [SLOT_FLD_W-1:0]   idx_q;
	logic [TOKEN_BITS-1:0]   key_q;
	logic                    done_q;
	rsp_t                    rsp_q;

	probe_t                  probe   [SLOT_COUNT+1];
	cell_ctl_t               ctl     [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   cell_valid;
	logic [TOKEN_BITS-1:0]   cell_token [SLOT_COUNT];

	logic                    accept;
	logic                    walk_end;
	logic                    save_ok;
	logic [SLOT_IDX_W-1:0]   win_slot;
	logic                    save_commit;
	logic                    remove_commit;
	logic                    clear_commit;
	logic [IDXW-1:0]         idx_w;
	logic                    in_range;
	logic [SLOT_W-1:0]       sel;
	rsp_t                    rsp_nxt;

	assign accept   = start && (state_q == ST_IDLE);
	assign walk_end = (state_q == ST_WALK) && probe[SLOT_COUNT].vld;

	assign idx_w    = IDXW'(idx_q);
	assign in_range = idx_w < IDXW'(SLOT_COUNT);
	assign sel      = idx_w[SLOT_W-1:0];

	assign save_ok  = probe[SLOT_COUNT].hit || probe[SLOT_COUNT].free;
	assign win_slot = probe[SLOT_COUNT].hit ? probe[SLOT_COUNT].hit_slot
	                                        : probe[SLOT_COUNT].free_slot;

	assign save_commit   = walk_end && (mode_q == MODE_SAVE) && save_ok;
	assign remove_commit = (state_q == ST_RESP) && (mode_q == MODE_REMOVE) && in_range;
	assign clear_commit  = (state_q == ST_RESP) && (mode_q == MODE_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.mode == MODE_SAVE || req.mode == MODE_FIND) begin
							state_q  <= ST_WALK;
							launch_q <= 1'b1;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_WALK: begin
					if (probe[SLOT_COUNT].vld) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			idx_q  <= req.slot_index;
			key_q  <= req.token_value[TOKEN_BITS-1:0];
		end
		if (walk_end || state_q == ST_RESP) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_comb begin
		rsp_nxt = '0;
		if (state_q == ST_WALK) begin
			unique case (mode_q)
				MODE_SAVE: begin
					if (save_ok) begin
						rsp_nxt.result_ok   = 1'b1;
						rsp_nxt.result_slot = win_slot[SLOT_FLD_W-1:0];
					end
				end
				MODE_FIND: begin
					if (probe[SLOT_COUNT].hit) begin
						rsp_nxt.result_ok   = 1'b1;
						rsp_nxt.result_slot = probe[SLOT_COUNT].hit_slot[SLOT_FLD_W-1:0];
					end
				end
				default: begin
					rsp_nxt = '0;
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_REMOVE: begin
					if (in_range) begin
						rsp_nxt.result_ok   = 1'b1;
						rsp_nxt.result_slot = idx_q;
					end
				end
				MODE_GET: begin
					if (in_range && cell_valid[sel]) begin
						rsp_nxt.result_ok    = 1'b1;
						rsp_nxt.result_token = TOKEN_W'(cell_token[sel]);
					end
				end
				MODE_CLEAR: begin
					rsp_nxt.result_ok = 1'b1;
				end
				default: begin
					rsp_nxt = '0;
				end
			endcase
		end
	end

	always_comb begin
		probe[0]     = '0;
		probe[0].vld = launch_q;
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		assign ctl[i].wr  = save_commit && (win_slot == SLOT_IDX_W'(i));
		assign ctl[i].inv = remove_commit && (sel == SLOT_W'(i));
		assign ctl[i].clr = clear_commit;

		twc_cell #(
			.TOKEN_BITS (TOKEN_BITS),
			.CELL_INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.key       (key_q),
			.probe_in  (probe[i]),
			.probe_out (probe[i+1]),
			.valid     (cell_valid[i]),
			.token     (cell_token[i])
		);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// every result closes a command that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a command in progress");

	// a search only travels the row while walking
	a_probe_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		probe[SLOT_COUNT].vld |-> (state_q == ST_WALK))
		else $error("search transfer outside walk state");

	// a failed command reports slot and token as zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.result_ok) |-> (rsp.result_slot == '0 && rsp.result_token == '0))
		else $error("failed result carries data");

	// a search is launched only on the cycle after a save or find transfer
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> ($past(accept) && state_q == ST_WALK))
		else $error("search launched without a command");

	// a save only ever targets a slot inside the table
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		save_commit |-> (win_slot < SLOT_IDX_W'(SLOT_COUNT)))
		else $error("save target beyond the table");

endmodule

`default_nettype wire

// ===== dv/token_whitelist_cache_tb.sv =====
// Self-checking testbench for the token whitelist cache: directed table, then random episodes.
`timescale 1ns / 1ps

module token_whitelist_cache_tb;
	import twc_pkg::*;

	localparam int SLOTS       = 32;
	localparam int TOK_BYTES   = 8;
	localparam int N_ITEMS     = 1300;
	localparam int DIR_N       = 24;
	localparam int POOL_N      = 16;
	localparam int CYCLE_LIMIT = 600_000;
	localparam int DRAIN_CYC   = SLOTS + 8;

	localparam logic [TOKEN_W-1:0] TOK_MASK =
		(TOK_BYTES >= 8) ? {TOKEN_W{1'b1}} : ((64'd1 << (8 * TOK_BYTES)) - 64'd1);
	localparam logic [TOKEN_W-1:0] TOK_ZERO = '0;
	localparam logic [TOKEN_W-1:0] TOK_ONES = {TOKEN_W{1'b1}};
	localparam logic [TOKEN_W-1:0] TOK_A5   = 64'h5555_5555_5555_5555;
	localparam logic [TOKEN_W-1:0] TOK_5A   = 64'haaaa_aaaa_aaaa_aaaa;
	localparam logic [TOKEN_W-1:0] TOK_ENDS = 64'h8000_0000_0000_0001;

	// mode codes the block does not define
	localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

	localparam logic KNOWN = 1'b1;
	localparam logic PRED  = 1'b0;
	localparam logic OK    = 1'b1;
	localparam logic NOK   = 1'b0;

	typedef struct packed {
		logic known;
		req_t rq;
		rsp_t rs;
	} dir_vec_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	// shadow copy of the table
	logic               shadow_valid [SLOTS];
	logic [TOKEN_W-1:0] shadow_token [SLOTS];

	rsp_t         pending_rsp [$];
	rsp_t         want_rsp;
	dir_vec_t     dir_tbl [DIR_N];
	logic [63:0]  tok_pool [POOL_N];
	int unsigned  err_count;
	int unsigned  sent;
	int unsigned  cycle_cnt = 0;
	bit           no_gap;

	token_whitelist_cache #(
		.SLOT_COUNT (SLOTS),
		.TOKEN_BYTES(TOK_BYTES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Works out the answer to one command and applies it to the shadow table.
	function automatic rsp_t cache_predict(input req_t r);
		rsp_t               o;
		logic [TOKEN_W-1:0] tok;
		int                 hit;
		o   = '0;
		tok = r.token_value & TOK_MASK;
		hit = -1;
		case (r.mode)
			MODE_SAVE, MODE_FIND: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (shadow_valid[i] && shadow_token[i] == tok)
						hit = i;
				if (r.mode == MODE_SAVE && hit < 0)
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!shadow_valid[i])
							hit = i;
				if (hit >= 0) begin
					o.result_ok   = 1'b1;
					o.result_slot = hit[SLOT_FLD_W-1:0];
					if (r.mode == MODE_SAVE) begin
						shadow_valid[hit] = 1'b1;
						shadow_token[hit] = tok;
					end
				end
			end
			MODE_REMOVE: begin
				if (r.slot_index < SLOTS) begin
					shadow_valid[r.slot_index] = 1'b0;
					o.result_ok   = 1'b1;
					o.result_slot = r.slot_index;
				end
			end
			MODE_GET: begin
				if (r.slot_index < SLOTS && shadow_valid[r.slot_index]) begin
					o.result_ok    = 1'b1;
					o.result_token = shadow_token[r.slot_index];
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					shadow_valid[i] = 1'b0;
				o.result_ok = 1'b1;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gap || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pick_token();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return tok_pool[$urandom_range(0, POOL_N - 1)];
		else if (r < 80)
			// near miss: one bit off a pooled token
			return tok_pool[$urandom_range(0, POOL_N - 1)] ^ (64'd1 << $urandom_range(0, 63));
		else
			return {$urandom, $urandom};
	endfunction

	function automatic req_t random_op();
		req_t        r;
		int unsigned p;
		p             = $urandom_range(0, 99);
		r.slot_index  = SLOT_FLD_W'($urandom_range(0, 31));
		r.token_value = pick_token();
		if (p < 35)
			r.mode = MODE_SAVE;
		else if (p < 60)
			r.mode = MODE_FIND;
		else if (p < 75)
			r.mode = MODE_REMOVE;
		else if (p < 90)
			r.mode = MODE_GET;
		else if (p < 93)
			r.mode = MODE_CLEAR;
		else
			r.mode = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
		return r;
	endfunction

	// One command transfer; start stays high into the next call when there is no gap.
	task automatic send_cmd(input req_t r, input logic known, input rsp_t rs);
		int unsigned gap;
		rsp_t        p;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		p = cache_predict(r);
		pending_rsp.push_back(known ? rs : p);
		sent++;
	endtask

	task automatic send_mixed(input int n);
		repeat (n) send_cmd(random_op(), PRED, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want_rsp = pending_rsp.pop_front();
				if (rsp.result_ok !== want_rsp.result_ok)
					report_mismatch($sformatf("result_ok %0b, expected %0b",
						rsp.result_ok, want_rsp.result_ok));
				if (rsp.result_slot !== want_rsp.result_slot)
					report_mismatch($sformatf("result_slot %0d, expected %0d",
						rsp.result_slot, want_rsp.result_slot));
				if (rsp.result_token !== want_rsp.result_token)
					report_mismatch($sformatf("result_token %h, expected %h",
						rsp.result_token, want_rsp.result_token));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		err_count = 0;
		sent      = 0;
		no_gap    = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_token[i] = '0;
		end

		//            known  mode         slot    token      ok   slot    token
		dir_tbl[ 0] = {KNOWN, MODE_GET,    5'd0,  TOK_ZERO, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[ 1] = {KNOWN, MODE_FIND,   5'd0,  TOK_ZERO, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[ 2] = {KNOWN, MODE_REMOVE, 5'd5,  TOK_ZERO, OK,  5'd5,  TOK_ZERO};
		dir_tbl[ 3] = {KNOWN, MODE_SAVE,   5'd31, TOK_ONES, OK,  5'd0,  TOK_ZERO};
		dir_tbl[ 4] = {KNOWN, MODE_SAVE,   5'd0,  TOK_ZERO, OK,  5'd1,  TOK_ZERO};
		dir_tbl[ 5] = {PRED,  MODE_FIND,   5'd7,  TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[ 6] = {PRED,  MODE_SAVE,   5'd3,  TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[ 7] = {KNOWN, MODE_GET,    5'd0,  TOK_ZERO, OK,  5'd0,  TOK_ONES};
		dir_tbl[ 8] = {KNOWN, MODE_GET,    5'd31, TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[ 9] = {KNOWN, MODE_RSVD5,  5'd31, TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[10] = {KNOWN, MODE_RSVD6,  5'd10, TOK_A5,   NOK, 5'd0,  TOK_ZERO};
		dir_tbl[11] = {KNOWN, MODE_RSVD7,  5'd21, TOK_5A,   NOK, 5'd0,  TOK_ZERO};
		dir_tbl[12] = {KNOWN, MODE_REMOVE, 5'd0,  TOK_ONES, OK,  5'd0,  TOK_ZERO};
		dir_tbl[13] = {PRED,  MODE_FIND,   5'd0,  TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[14] = {PRED,  MODE_GET,    5'd0,  TOK_ZERO, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[15] = {PRED,  MODE_SAVE,   5'd21, TOK_A5,   NOK, 5'd0,  TOK_ZERO};
		dir_tbl[16] = {PRED,  MODE_SAVE,   5'd10, TOK_5A,   NOK, 5'd0,  TOK_ZERO};
		dir_tbl[17] = {PRED,  MODE_GET,    5'd1,  TOK_ONES, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[18] = {KNOWN, MODE_REMOVE, 5'd31, TOK_ZERO, OK,  5'd31, TOK_ZERO};
		dir_tbl[19] = {PRED,  MODE_FIND,   5'd0,  TOK_ZERO, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[20] = {KNOWN, MODE_CLEAR,  5'd31, TOK_ONES, OK,  5'd0,  TOK_ZERO};
		dir_tbl[21] = {PRED,  MODE_FIND,   5'd0,  TOK_A5,   NOK, 5'd0,  TOK_ZERO};
		dir_tbl[22] = {PRED,  MODE_GET,    5'd2,  TOK_ZERO, NOK, 5'd0,  TOK_ZERO};
		dir_tbl[23] = {PRED,  MODE_SAVE,   5'd0,  TOK_ENDS, NOK, 5'd0,  TOK_ZERO};

		for (int i = 0; i < POOL_N; i++)
			tok_pool[i] = {$urandom, $urandom};

		start  <= 1'b0;
		req    <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_cmd(dir_tbl[i].rq, dir_tbl[i].known, dir_tbl[i].rs);

		while (sent < N_ITEMS) begin
			no_gap = ($urandom_range(0, 3) == 0);
			tok_pool[$urandom_range(0, POOL_N - 1)] = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0, 1: begin
					// fill the table with fresh tokens and run past full
					n = $urandom_range(SLOTS, SLOTS + 6);
					repeat (n)
						send_cmd({MODE_SAVE, 5'($urandom_range(0, 31)), {$urandom, $urandom}},
							PRED, '0);
					send_mixed(8);
				end
				2: begin
					send_cmd({MODE_CLEAR, 5'($urandom_range(0, 31)), {$urandom, $urandom}},
						PRED, '0);
					send_mixed(20);
				end
				default: send_mixed(30);
			endcase
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
sv/twc_pkg.sv
sv/twc_cell.sv
sv/token_whitelist_cache.sv
dv/token_whitelist_cache_tb.sv
